/* rtl/core/tcpq_pkg.sv */
// shared types, constants and codes for the two class priority queue server
// no dependencies
package tcpq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int SUM_W       = PTR_W + 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W     = 48;
   localparam int LIMIT_W     = 5;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
   localparam logic [0:0]         REG_ADMIT_CAP = 1'b0;

   localparam logic [1:0] CMD_REQ_A = 2'd0;
   localparam logic [1:0] CMD_REQ_B = 2'd1;
   localparam logic [1:0] CMD_SERVE = 2'd2;

   localparam logic [1:0] PREF_BOTH   = 2'd0;
   localparam logic [1:0] PREF_A_ONLY = 2'd1;
   localparam logic [1:0] PREF_B_ONLY = 2'd2;

   localparam logic [1:0] SERVED_IDLE = 2'd0;
   localparam logic [1:0] SERVED_A    = 2'd1;
   localparam logic [1:0] SERVED_B    = 2'd2;

   localparam logic STATUS_ADMIT  = 1'b0;
   localparam logic STATUS_REFUSE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic accept;
      logic exec;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] item_id;
      logic [31:0] arrival_time;
      logic [31:0] now_time;
      logic [1:0]  preference;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [1:0]  served_class;
      logic [15:0] served_id;
      logic [4:0]  count_a;
      logic [4:0]  count_b;
      logic [31:0] refused_a;
      logic [31:0] refused_b;
      logic [31:0] served_a;
      logic [31:0] served_b;
      logic [31:0] wait_total_a;
      logic [31:0] wait_total_b;
      logic [31:0] idle_total;
   } rsp_type;

endpackage

/* rtl/core/two_class_priority_queue_server_core.sv */
// top level of the two class strict priority queue server
// depends on tcpq_pkg, tcpq_ctrl, tcpq_dp (and tcpq_ram through tcpq_dp)
//
// command channel: req_data (cmd, item_id, arrival_time, now_time, preference)
// transfers at a rising edge where start is high and busy is low
// result channel: rsp_data is valid for exactly one cycle while rsp_valid is
// high; the receiver takes it at the edge that ends that cycle and cannot stall
// latency: the command transfers, the next cycle executes (busy high), and the
// result strobe follows in the cycle after that
// command flow: no command transfers while busy; start may be held high through the
// result cycle to transfer the next command there. the gap between commands is
// set by the execute state, which needs the queue head from the registered ram read
// configuration: apb-style port, admit cap register at byte address 0, reset 16
// reset: synchronous, clears both queues, all counters and the controller, and
// restores the admit cap to 16; no clearing pass is needed
module two_class_priority_queue_server_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  tcpq_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output tcpq_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tcpq_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [tcpq_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [tcpq_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import tcpq_pkg::*;

   ctl_cmd_type        ctl;
   logic [LIMIT_W-1:0] limit_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == REG_ADMIT_CAP)) begin
         limit_ff <= pwdata[LIMIT_W-1:0];
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_ADMIT_CAP: prdata = CSR_DATA_W'(limit_ff);
         default:       prdata = '0;
      endcase
   end

   tcpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   tcpq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_data  (req_data),
      .admit_cap (limit_ff),
      .rsp_data  (rsp_data)
   );

   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy) else $error("execute lasted more than one cycle");

   a_accept_starts_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("transfer did not start execution");

   a_result_after_exec: assert property (@(posedge clock) disable iff (reset)
      busy |=> rsp_valid) else $error("no result after execute cycle");

   a_refuse_not_served: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_REFUSE)) |->
         ((rsp_data.served_class == SERVED_IDLE) && (rsp_data.served_id == '0)))
      else $error("refused request reports a served item");

endmodule

/* rtl/core/tcpq_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
module tcpq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/tcpq_ctrl.sv */
// controller state machine: accept, execute, result strobe
// depends on tcpq_pkg
module tcpq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output tcpq_pkg::ctl_cmd_type ctl
);
   import tcpq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = start ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy       = 1'b0;
      rsp_valid  = 1'b0;
      ctl.accept = 1'b0;
      ctl.exec   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.accept = start;
         end
         ST_EXEC: begin
            busy     = 1'b1;
            ctl.exec = 1'b1;
         end
         ST_RESP: begin
            rsp_valid  = 1'b1;
            ctl.accept = start;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

/* rtl/core/tcpq_dp.sv */
// datapath: two queue rams, pointers, fill counts, saturating counters, result register
// depends on tcpq_pkg and tcpq_ram
module tcpq_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  tcpq_pkg::ctl_cmd_type         ctl,
   input  tcpq_pkg::req_type             req_data,
   input  logic [tcpq_pkg::LIMIT_W-1:0]  admit_cap,
   output tcpq_pkg::rsp_type             rsp_data
);
   import tcpq_pkg::*;

   function automatic logic [31:0] sat_inc(input logic [31:0] a);
      return (a == '1) ? a : a + 32'd1;
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? '1 : s[31:0];
   endfunction

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (SUM_W'(p) == SUM_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] tail_of(input logic [PTR_W-1:0] h,
                                                input logic [CNT_W-1:0] f);
      logic [SUM_W-1:0] s;
      s = SUM_W'(h) + SUM_W'(f);
      if (s >= SUM_W'(QUEUE_DEPTH)) s = s - SUM_W'(QUEUE_DEPTH);
      return s[PTR_W-1:0];
   endfunction

   req_type           req_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;
   logic [PTR_W-1:0]  head_a_ff, head_a_in, head_b_ff, head_b_in;
   logic [CNT_W-1:0]  fill_a_ff, fill_a_in, fill_b_ff, fill_b_in;
   logic [31:0]       refused_a_ff, refused_a_in, refused_b_ff, refused_b_in;
   logic [31:0]       served_a_ff, served_a_in, served_b_ff, served_b_in;
   logic [31:0]       wait_a_ff, wait_a_in, wait_b_ff, wait_b_in;
   logic [31:0]       idle_ff, idle_in;
   logic [CNT_W-1:0]  lim_eff;
   logic [ENTRY_W-1:0] rd_a, rd_b, wr_entry;
   logic              push_a, push_b;
   logic              take_a, take_b;
   logic [31:0]       wait_a, wait_b;

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         req_ff <= req_data;
      end
      if (ctl.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_a_ff    <= '0;
         head_b_ff    <= '0;
         fill_a_ff    <= '0;
         fill_b_ff    <= '0;
         refused_a_ff <= '0;
         refused_b_ff <= '0;
         served_a_ff  <= '0;
         served_b_ff  <= '0;
         wait_a_ff    <= '0;
         wait_b_ff    <= '0;
         idle_ff      <= '0;
      end else if (ctl.exec) begin
         head_a_ff    <= head_a_in;
         head_b_ff    <= head_b_in;
         fill_a_ff    <= fill_a_in;
         fill_b_ff    <= fill_b_in;
         refused_a_ff <= refused_a_in;
         refused_b_ff <= refused_b_in;
         served_a_ff  <= served_a_in;
         served_b_ff  <= served_b_in;
         wait_a_ff    <= wait_a_in;
         wait_b_ff    <= wait_b_in;
         idle_ff      <= idle_in;
      end
   end

   assign lim_eff  = (32'(admit_cap) > 32'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH)
                                                         : CNT_W'(admit_cap);
   assign wr_entry = {req_ff.item_id, req_ff.arrival_time};
   assign wait_a   = req_ff.now_time - rd_a[31:0];
   assign wait_b   = req_ff.now_time - rd_b[31:0];

   always_comb begin
      head_a_in    = head_a_ff;
      head_b_in    = head_b_ff;
      fill_a_in    = fill_a_ff;
      fill_b_in    = fill_b_ff;
      refused_a_in = refused_a_ff;
      refused_b_in = refused_b_ff;
      served_a_in  = served_a_ff;
      served_b_in  = served_b_ff;
      wait_a_in    = wait_a_ff;
      wait_b_in    = wait_b_ff;
      idle_in      = idle_ff;
      push_a       = 1'b0;
      push_b       = 1'b0;
      take_a       = 1'b0;
      take_b       = 1'b0;
      rsp_in.status       = STATUS_ADMIT;
      rsp_in.served_class = SERVED_IDLE;
      rsp_in.served_id    = '0;
      case (req_ff.cmd)
         CMD_REQ_A: begin
            if (fill_a_ff < lim_eff) begin
               push_a    = 1'b1;
               fill_a_in = fill_a_ff + CNT_W'(1);
            end else begin
               rsp_in.status = STATUS_REFUSE;
               refused_a_in  = sat_inc(refused_a_ff);
            end
         end
         CMD_REQ_B: begin
            if (fill_b_ff < lim_eff) begin
               push_b    = 1'b1;
               fill_b_in = fill_b_ff + CNT_W'(1);
            end else begin
               rsp_in.status = STATUS_REFUSE;
               refused_b_in  = sat_inc(refused_b_ff);
            end
         end
         CMD_SERVE: begin
            take_a = (req_ff.preference != PREF_B_ONLY) && (fill_a_ff != '0);
            take_b = !take_a && (req_ff.preference != PREF_A_ONLY) && (fill_b_ff != '0);
            if (take_a) begin
               head_a_in           = ptr_inc(head_a_ff);
               fill_a_in           = fill_a_ff - CNT_W'(1);
               wait_a_in           = sat_add(wait_a_ff, wait_a);
               served_a_in         = sat_inc(served_a_ff);
               rsp_in.served_class = SERVED_A;
               rsp_in.served_id    = rd_a[47:32];
            end else if (take_b) begin
               head_b_in           = ptr_inc(head_b_ff);
               fill_b_in           = fill_b_ff - CNT_W'(1);
               wait_b_in           = sat_add(wait_b_ff, wait_b);
               served_b_in         = sat_inc(served_b_ff);
               rsp_in.served_class = SERVED_B;
               rsp_in.served_id    = rd_b[47:32];
            end else if ((req_ff.preference != PREF_A_ONLY) &&
                         (req_ff.preference != PREF_B_ONLY)) begin
               idle_in = sat_inc(idle_ff);
            end
         end
         default: begin
            rsp_in.status = STATUS_ADMIT;
         end
      endcase
      rsp_in.count_a      = 5'(fill_a_in);
      rsp_in.count_b      = 5'(fill_b_in);
      rsp_in.refused_a    = refused_a_in;
      rsp_in.refused_b    = refused_b_in;
      rsp_in.served_a     = served_a_in;
      rsp_in.served_b     = served_b_in;
      rsp_in.wait_total_a = wait_a_in;
      rsp_in.wait_total_b = wait_b_in;
      rsp_in.idle_total   = idle_in;
   end

   tcpq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram_a (
      .clock (clock),
      .we    (ctl.exec && push_a),
      .waddr (tail_of(head_a_ff, fill_a_ff)),
      .wdata (wr_entry),
      .raddr (head_a_ff),
      .rdata (rd_a)
   );

   tcpq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram_b (
      .clock (clock),
      .we    (ctl.exec && push_b),
      .waddr (tail_of(head_b_ff, fill_b_ff)),
      .wdata (wr_entry),
      .raddr (head_b_ff),
      .rdata (rd_b)
   );

   assign rsp_data = rsp_ff;

endmodule
